// ===== hw/rtl/ffba_pkg.sv =====
// shared constants, tag type and request codes of the first-fit block map allocator
`default_nettype none

package ffba_pkg;

    localparam int NUM_BLOCKS  = 256;
    localparam int BLOCK_BYTES = 1024;

    localparam int BLK_W       = $clog2(NUM_BLOCKS);
    localparam int LEN_W       = BLK_W + 1;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int BYTE_W      = 19;
    localparam int NEED_W      = BYTE_W + 1 - BLOCK_SHIFT;
    localparam int END_W       = NEED_W + 1;
    localparam int OFFSET_W    = 18;
    localparam int ENTRY_W     = 8;
    localparam int KIND_W      = 2;

    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 56;

    localparam logic REQ_PLACE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIR    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd2;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry;
        logic [KIND_W-1:0]  kind;
    } tag_t;

    localparam tag_t TAG_UNUSED = '{entry: '0, kind: KIND_UNUSED};
    localparam tag_t TAG_DIR    = '{entry: '0, kind: KIND_DIR};

endpackage

`default_nettype wire

// ===== hw/rtl/first_fit_block_map_allocator.sv =====
// first-fit contiguous block allocator over a block map held in one memory
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+------------------------------------------
//  s_*      | in  | s_tvalid / s_tready        | tuser req_type, tdata request fields
//  m_*      | out | m_tvalid / m_tready        | tdata result fields
//
//  a read request passes ST_READ, which fills the result fields, then ST_FIN, which
//  loads the output register; a place request passes ST_SCAN and ST_DECIDE and, if a
//  run fits, ST_WRITE: the single read port of the tag memory walks the map once to
//  find the run and once more to free the old blocks and tag the new run
//  no clearing pass after reset: used_length acts as fill count (blocks at or past it
//  read unused) and a flag makes block 0 read as directory until it is first written
//  a new item is taken only in idle; a finished result waits in the output register
//  while the next item is accepted, and a stalled m_tready holds the block before idle
`default_nettype none

module first_fit_block_map_allocator
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [0] req_type
    input  wire logic                            s_tuser,
    // [0] owner_is_directory, [8:1] entry_index, [27:9] byte_count, [35:28] block_index
    input  wire logic [ffba_pkg::IN_DATA_W-1:0]  s_tdata,

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] start_block, [25:8] byte_offset, [34:26] block_count, [35] no_space,
    // [37:36] owner_kind, [45:38] owner_entry, [54:46] map_length
    output logic [ffba_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import ffba_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    // request fields
    logic              in_req;
    logic              in_is_dir;
    logic [ENTRY_W-1:0] in_entry;
    logic [BYTE_W-1:0] in_bytes;
    logic [BLK_W-1:0]  in_block;

    assign in_req    = s_tuser;
    assign in_is_dir = s_tdata[0];
    assign in_entry  = s_tdata[8:1];
    assign in_bytes  = s_tdata[27:9];
    assign in_block  = s_tdata[35:28];

    // control state
    logic [2:0]       state_reg, state_next;
    logic [LEN_W-1:0] used_length_reg, used_length_next;
    logic             blk0_wr_reg, blk0_wr_next;
    logic             out_valid_reg, out_valid_next;

    // datapath state
    logic [BLK_W-1:0]      idx_reg, idx_next;
    tag_t                  owner_reg, owner_next;
    logic [NEED_W-1:0]     need_reg, need_next;
    logic [LEN_W-1:0]      so_far_reg, so_far_next;
    logic [LEN_W-1:0]      pos_reg, pos_next;
    logic [BLK_W-1:0]      start_reg, start_next;
    logic [LEN_W-1:0]      end_reg, end_next;
    logic [LEN_W-1:0]      wlim_reg, wlim_next;
    logic [BLK_W-1:0]      res_start_reg, res_start_next;
    logic [OFFSET_W-1:0]   res_offset_reg, res_offset_next;
    logic [LEN_W-1:0]      res_count_reg, res_count_next;
    logic                  res_nospace_reg, res_nospace_next;
    logic [KIND_W-1:0]     res_kind_reg, res_kind_next;
    logic [ENTRY_W-1:0]    res_entry_reg, res_entry_next;
    logic [LEN_W-1:0]      res_len_reg, res_len_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // tag memory: one read and one write port, registered read
    tag_t             tag_mem [0:NUM_BLOCKS-1];
    tag_t             rd_data_reg;
    logic [BLK_W-1:0] mem_raddr;
    logic             mem_we;
    logic [BLK_W-1:0] mem_waddr;
    tag_t             mem_wdata;

    // tag seen at idx_reg after fill-count and block 0 override
    tag_t              eff_tag;
    logic              is_free;
    logic [LEN_W-1:0]  so_far_inc;
    logic [LEN_W-1:0]  idx_plus1;
    logic [LEN_W-1:0]  start_w;
    logic [END_W-1:0]  end_w;
    logic [NEED_W+BLOCK_SHIFT-1:0] bytes_up;
    logic              in_run;

    assign idx_plus1 = {1'b0, idx_reg} + LEN_W'(1);

    always_comb
    begin
        if (idx_reg == '0 && !blk0_wr_reg)
        begin
            eff_tag = TAG_DIR;
        end
        else if ({1'b0, idx_reg} >= used_length_reg)
        begin
            eff_tag = TAG_UNUSED;
        end
        else
        begin
            eff_tag = rd_data_reg;
        end
    end

    assign is_free    = (eff_tag.kind == KIND_UNUSED) || (eff_tag == owner_reg);
    assign so_far_inc = is_free ? so_far_reg + LEN_W'(1) : '0;
    assign start_w    = pos_reg - so_far_reg;
    assign end_w      = END_W'(start_w) + END_W'(need_reg);
    assign bytes_up   = (NEED_W+BLOCK_SHIFT)'(in_bytes) + (NEED_W+BLOCK_SHIFT)'(BLOCK_BYTES - 1);
    assign in_run     = ({1'b0, idx_reg} >= {1'b0, start_reg}) && ({1'b0, idx_reg} < end_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next       = state_reg;
        used_length_next = used_length_reg;
        blk0_wr_next     = blk0_wr_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        owner_next       = owner_reg;
        need_next        = need_reg;
        so_far_next      = so_far_reg;
        pos_next         = pos_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        wlim_next        = wlim_reg;
        res_start_next   = res_start_reg;
        res_offset_next  = res_offset_reg;
        res_count_next   = res_count_reg;
        res_nospace_next = res_nospace_reg;
        res_kind_next    = res_kind_reg;
        res_entry_next   = res_entry_reg;
        res_len_next     = res_len_reg;
        out_data_next    = out_data_reg;
        mem_raddr        = idx_plus1[BLK_W-1:0];
        mem_we           = 1'b0;
        mem_waddr        = idx_reg;
        mem_wdata        = TAG_UNUSED;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_req == REQ_READ)
                    begin
                        mem_raddr  = in_block;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        // entry numbers fill the whole field, so no wrap is needed
                        owner_next  = in_is_dir ? TAG_DIR
                                                : tag_t'{entry: in_entry, kind: KIND_ENTRY};
                        need_next   = bytes_up[NEED_W+BLOCK_SHIFT-1:BLOCK_SHIFT];
                        so_far_next = '0;
                        mem_raddr   = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end

            ST_READ:
            begin
                res_start_next   = '0;
                res_offset_next  = '0;
                res_count_next   = '0;
                res_nospace_next = 1'b0;
                res_kind_next    = eff_tag.kind;
                res_entry_next   = (eff_tag.kind == KIND_ENTRY) ? eff_tag.entry : '0;
                res_len_next     = used_length_reg;
                state_next       = ST_FIN;
            end

            ST_SCAN:
            begin
                // free run length so far; a run counts blocks the owner already holds
                so_far_next = so_far_inc;
                if ((END_W'(need_reg) <= END_W'(so_far_inc)) || (idx_plus1 == used_length_reg))
                begin
                    pos_next   = idx_plus1;
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (end_w > END_W'(NUM_BLOCKS))
                begin
                    res_start_next   = '0;
                    res_offset_next  = '0;
                    res_count_next   = '0;
                    res_nospace_next = 1'b1;
                    res_kind_next    = KIND_UNUSED;
                    res_entry_next   = '0;
                    res_len_next     = used_length_reg;
                    state_next       = ST_FIN;
                end
                else
                begin
                    start_next = start_w[BLK_W-1:0];
                    end_next   = end_w[LEN_W-1:0];
                    wlim_next  = (end_w[LEN_W-1:0] > used_length_reg) ? end_w[LEN_W-1:0]
                                                                        : used_length_reg;
                    res_start_next   = start_w[BLK_W-1:0];
                    res_offset_next  = OFFSET_W'({start_w[BLK_W-1:0], {BLOCK_SHIFT{1'b0}}});
                    res_count_next   = need_reg[LEN_W-1:0];
                    res_nospace_next = 1'b0;
                    res_kind_next    = KIND_UNUSED;
                    res_entry_next   = '0;
                    res_len_next     = wlim_next;
                    mem_raddr        = '0;
                    state_next       = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                // read-ahead one block, write back the block read last cycle
                if (in_run)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = owner_reg;
                end
                else if (eff_tag == owner_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = TAG_UNUSED;
                end
                if (mem_we && idx_reg == '0)
                begin
                    blk0_wr_next = 1'b1;
                end
                if (idx_plus1 == wlim_reg)
                begin
                    used_length_next = wlim_reg;
                    state_next       = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = OUT_DATA_W'({res_len_reg, res_entry_reg, res_kind_reg,
                                                  res_nospace_reg, res_count_reg,
                                                  res_offset_reg, res_start_reg});
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        idx_next = mem_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            used_length_reg <= LEN_W'(1);
            blk0_wr_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            used_length_reg <= used_length_next;
            blk0_wr_reg     <= blk0_wr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        owner_reg       <= owner_next;
        need_reg        <= need_next;
        so_far_reg      <= so_far_next;
        pos_reg         <= pos_next;
        start_reg       <= start_next;
        end_reg         <= end_next;
        wlim_reg        <= wlim_next;
        res_start_reg   <= res_start_next;
        res_offset_reg  <= res_offset_next;
        res_count_reg   <= res_count_next;
        res_nospace_reg <= res_nospace_next;
        res_kind_reg    <= res_kind_next;
        res_entry_reg   <= res_entry_next;
        res_len_reg     <= res_len_next;
        out_data_reg    <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= tag_mem[mem_raddr];
    end

    // map length stays within capacity and never shrinks
    assert property (@(posedge clk) disable iff (!rst_n)
        (used_length_reg != '0) && (used_length_reg <= LEN_W'(NUM_BLOCKS)))
        else $error("map length out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> used_length_reg >= $past(used_length_reg))
        else $error("map length shrank");

    // write-back stays inside the walked part of the map
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_WRITE) && ({1'b0, idx_reg} < wlim_reg))
        else $error("tag write outside write pass");

    // a refused placement reports no run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[35]) |-> (m_tdata[34:0] == '0))
        else $error("no-space result carries a run");

endmodule

`default_nettype wire
